### rtl/core/asc_pkg.sv
// asc_pkg: shared types, constants and the control program of the alpha synapse unit.
// Standalone; imported by alpha_synapse_current_unit, asc_seq and asc_dp.
package asc_pkg;

    // table geometry
    localparam int ALPHA_TABLE_DEPTH = 1024;
    localparam int IDX_W = $clog2(ALPHA_TABLE_DEPTH);
    localparam int CNT_W = $clog2(IDX_W);

    // table recurrence seeds: e in Q2.30, exp(-1/256) in Q0.32
    localparam logic [31:0] E_Q2_30     = 32'd2918732889;
    localparam logic [31:0] DECAY_Q0_32 = 32'd4278222805;

    // shared multiplier operand width (signed)
    localparam int MUL_W = 33;

    // input item kinds
    typedef enum logic [1:0] {
        K_ACTIVATE   = 2'd0,
        K_DEACTIVATE = 2'd1,
        K_QUERY      = 2'd2
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] CFG_PEAK = 2'd0;
    localparam logic [1:0] CFG_TAU  = 2'd1;
    localparam logic [1:0] CFG_REV  = 2'd2;

    typedef struct packed {
        logic [15:0] peak;
        logic [15:0] tau;
        logic [15:0] rev;
    } t_cfg;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_FILL_INIT,
        OP_FILL_ENT,
        OP_FILL_WR,
        OP_FILL_NEXT,
        OP_PUSH,
        OP_TAKE,
        OP_APPLY,
        OP_RANGE,
        OP_DIV,
        OP_MUL_GA,
        OP_MUL_DV,
        OP_SAT
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_FILL_MORE,
        C_OUT_BUSY,
        C_NO_IN,
        C_NO_QUERY,
        C_OUT_RANGE,
        C_CNT_NZ
    } t_cond;

    localparam int UPC_W = 4;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_cword;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic fill_more;
        logic out_busy;
        logic no_query;
        logic out_range;
        logic cnt_nz;
    } t_status;

    // program addresses
    localparam logic [UPC_W-1:0] UA_FILL_INIT = 4'd0;
    localparam logic [UPC_W-1:0] UA_FILL_ENT  = 4'd1;
    localparam logic [UPC_W-1:0] UA_FILL_WR   = 4'd2;
    localparam logic [UPC_W-1:0] UA_FILL_NEXT = 4'd3;
    localparam logic [UPC_W-1:0] UA_GO_IDLE   = 4'd4;
    localparam logic [UPC_W-1:0] UA_FINISH    = 4'd5;
    localparam logic [UPC_W-1:0] UA_IDLE      = 4'd6;
    localparam logic [UPC_W-1:0] UA_APPLY     = 4'd7;
    localparam logic [UPC_W-1:0] UA_RANGE     = 4'd8;
    localparam logic [UPC_W-1:0] UA_DIV       = 4'd9;
    localparam logic [UPC_W-1:0] UA_LOOKUP    = 4'd10;
    localparam logic [UPC_W-1:0] UA_MUL_GA    = 4'd11;
    localparam logic [UPC_W-1:0] UA_MUL_DV    = 4'd12;
    localparam logic [UPC_W-1:0] UA_SAT       = 4'd13;

    // control store: a taken condition jumps to target, else falls through
    function automatic t_cword ucode(input logic [UPC_W-1:0] addr);
        t_cword w;
        case (addr)
            UA_FILL_INIT: w = '{op: OP_FILL_INIT, cond: C_NEVER,     target: UA_FILL_INIT};
            UA_FILL_ENT:  w = '{op: OP_FILL_ENT,  cond: C_NEVER,     target: UA_FILL_ENT};
            UA_FILL_WR:   w = '{op: OP_FILL_WR,   cond: C_NEVER,     target: UA_FILL_WR};
            UA_FILL_NEXT: w = '{op: OP_FILL_NEXT, cond: C_FILL_MORE, target: UA_FILL_ENT};
            UA_GO_IDLE:   w = '{op: OP_NOP,       cond: C_ALWAYS,    target: UA_IDLE};
            UA_FINISH:    w = '{op: OP_PUSH,      cond: C_OUT_BUSY,  target: UA_FINISH};
            UA_IDLE:      w = '{op: OP_TAKE,      cond: C_NO_IN,     target: UA_IDLE};
            UA_APPLY:     w = '{op: OP_APPLY,     cond: C_NO_QUERY,  target: UA_FINISH};
            UA_RANGE:     w = '{op: OP_RANGE,     cond: C_OUT_RANGE, target: UA_FINISH};
            UA_DIV:       w = '{op: OP_DIV,       cond: C_CNT_NZ,    target: UA_DIV};
            UA_LOOKUP:    w = '{op: OP_NOP,       cond: C_NEVER,     target: UA_LOOKUP};
            UA_MUL_GA:    w = '{op: OP_MUL_GA,    cond: C_NEVER,     target: UA_MUL_GA};
            UA_MUL_DV:    w = '{op: OP_MUL_DV,    cond: C_NEVER,     target: UA_MUL_DV};
            UA_SAT:       w = '{op: OP_SAT,       cond: C_ALWAYS,    target: UA_FINISH};
            default:      w = '{op: OP_NOP,       cond: C_ALWAYS,    target: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/alpha_synapse_current_unit.sv
// Alpha synapse current unit: an in-range query passes apply, range check, divider loop,
// table lookup, two multiplies and saturation before its result is pushed; activate,
// deactivate, ignored, inactive and early requests go from apply to the push, an
// out-of-range query from the range check. Divider loop sets the rate; a stalled result
// adds its wait. Uses asc_pkg, asc_seq, asc_dp. Synchronous active-low reset clears state,
// then a table fill pass runs with input stalled; config writes still apply.
module alpha_synapse_current_unit
    import asc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_time_tick,
    input  logic [15:0] i_membrane_voltage,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_syn_current,
    output logic        o_is_on
);

    t_cfg    r_cfg;
    t_cword  cw;
    t_status status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak <= 16'd0;
            r_cfg.tau  <= 16'd1;
            r_cfg.rev  <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PEAK: r_cfg.peak <= i_cfg_data;
                CFG_TAU:  r_cfg.tau  <= i_cfg_data;
                CFG_REV:  r_cfg.rev  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // requests are taken only at the idle step
    assign o_stall = (cw.op != OP_TAKE);

    asc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cw     (cw)
    );

    asc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cw               (cw),
        .i_cfg              (r_cfg),
        .i_valid            (i_valid),
        .i_kind             (i_kind),
        .i_time_tick        (i_time_tick),
        .i_membrane_voltage (i_membrane_voltage),
        .i_stall            (i_stall),
        .o_status           (status),
        .o_valid            (o_valid),
        .o_syn_current      (o_syn_current),
        .o_is_on            (o_is_on)
    );

endmodule

### rtl/core/asc_ram.sv
// asc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module asc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/asc_seq.sv
// asc_seq: step counter and control store of the alpha synapse unit.
// Depends on asc_pkg (control word, conditions, program).
module asc_seq
    import asc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cword  o_cw
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_cword           cw;
    logic             taken;

    assign cw = ucode(r_upc);

    // jump condition select
    always_comb begin
        case (cw.cond)
            C_NEVER:     taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_FILL_MORE: taken = i_status.fill_more;
            C_OUT_BUSY:  taken = i_status.out_busy;
            C_NO_IN:     taken = !i_valid;
            C_NO_QUERY:  taken = i_status.no_query;
            C_OUT_RANGE: taken = i_status.out_range;
            C_CNT_NZ:    taken = i_status.cnt_nz;
            default:     taken = 1'b0;
        endcase
    end

    assign n_upc = taken ? cw.target : r_upc + 1'b1;

    // step counter; reset starts the table fill program
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_FILL_INIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_cw = cw;

endmodule

### rtl/core/asc_dp.sv
// asc_dp: datapath of the alpha synapse unit: onset state, divider, shared multiplier,
// alpha table RAM and output register. Depends on asc_pkg and asc_ram.
module asc_dp
    import asc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cword      i_cw,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_time_tick,
    input  logic [15:0] i_membrane_voltage,
    input  logic        i_stall,
    output t_status     o_status,
    output logic        o_valid,
    output logic [31:0] o_syn_current,
    output logic        o_is_on
);

    // request and onset state
    logic [1:0]  r_kind;
    logic [31:0] r_time;
    logic [15:0] r_vm;
    logic [31:0] r_onset_time;
    logic        r_onset_valid;

    // arithmetic registers
    logic [31:0]       r_diff;
    logic [15:0]       r_rem;
    logic [IDX_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic [63:0]       r_prod;
    logic signed [16:0] r_dv;
    logic [31:0]       r_cur;

    // table fill registers
    logic [IDX_W-1:0] r_k;
    logic [31:0]      r_p;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_cur;
    logic        r_out_on;

    logic [15:0]            tau_eff;
    logic [39:0]            n_full;
    logic [39:0]            n_hi;
    logic [IDX_W-1:0]       n_low;
    logic [16:0]            trial;
    logic                   trial_ge;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic                   mul_en;
    logic [64:0]            p_round;
    logic [63:0]            ent_round;
    logic signed [63:0]     prod_sh;
    logic [31:0]            sat_cur;
    logic [15:0]            ram_rdata;
    logic                   ram_we;
    logic                   in_acc;
    logic                   out_free;
    logic                   out_load;

    assign tau_eff = (i_cfg.tau == 16'd0) ? 16'd1 : i_cfg.tau;

    // dividend (t - onset) * 256, split for long division
    assign n_full = {r_diff, 8'h00};
    assign n_hi   = n_full >> IDX_W;
    assign n_low  = n_full[IDX_W-1:0];

    // one restoring division step
    assign trial    = {r_rem, n_low[r_cnt]};
    assign trial_ge = trial >= {1'b0, tau_eff};

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        case (i_cw.op)
            OP_FILL_ENT: begin
                mul_a = $signed({{(MUL_W-IDX_W){1'b0}}, r_k});
                mul_b = $signed({1'b0, r_p});
            end
            OP_FILL_WR: begin
                mul_a = $signed({1'b0, r_p});
                mul_b = $signed({1'b0, DECAY_Q0_32});
            end
            OP_APPLY: begin
                mul_a = $signed(MUL_W'(ALPHA_TABLE_DEPTH));
                mul_b = $signed({{(MUL_W-16){1'b0}}, tau_eff});
            end
            OP_MUL_GA: begin
                mul_a = $signed({{(MUL_W-16){1'b0}}, i_cfg.peak});
                mul_b = $signed({{(MUL_W-16){1'b0}}, ram_rdata});
            end
            OP_MUL_DV: begin
                mul_a = $signed({1'b0, r_prod[31:0]});
                mul_b = $signed({{(MUL_W-17){r_dv[16]}}, r_dv});
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // table recurrence rounding
    assign p_round   = {1'b0, r_prod} + 65'h0_8000_0000;
    assign ent_round = r_prod + 64'h40_0000;

    // floor shift by 2^15 and saturation to 32 bits
    assign prod_sh = $signed(r_prod) >>> 15;
    always_comb begin
        if (prod_sh > 64'sh0000_0000_7FFF_FFFF) begin
            sat_cur = 32'h7FFF_FFFF;
        end else if (prod_sh < -64'sh0000_0000_8000_0000) begin
            sat_cur = 32'h8000_0000;
        end else begin
            sat_cur = prod_sh[31:0];
        end
    end

    assign in_acc   = (i_cw.op == OP_TAKE) && i_valid;
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (i_cw.op == OP_PUSH) && out_free;
    assign ram_we   = (i_cw.op == OP_FILL_WR);

    // alpha table, filled after reset, read at the quotient
    asc_ram #(
        .WIDTH (16),
        .DEPTH (ALPHA_TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_k),
        .i_wdata (ent_round[38:23]),
        .i_raddr (r_quo),
        .o_rdata (ram_rdata)
    );

    // onset state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_onset_time  <= '0;
            r_onset_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cw.op == OP_APPLY) begin
                if (r_kind == K_ACTIVATE) begin
                    r_onset_time  <= r_time;
                    r_onset_valid <= 1'b1;
                end else if (r_kind == K_DEACTIVATE) begin
                    r_onset_time  <= '0;
                    r_onset_valid <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_kind;
            r_time <= i_time_tick;
            r_vm   <= i_membrane_voltage;
        end
        if (mul_en) begin
            r_prod <= mul_p[63:0];
        end
        case (i_cw.op)
            OP_FILL_INIT: begin
                r_k <= '0;
                r_p <= E_Q2_30;
            end
            OP_FILL_NEXT: begin
                r_k <= r_k + 1'b1;
                r_p <= p_round[63:32];
            end
            OP_APPLY: begin
                r_diff <= r_time - r_onset_time;
                r_cur  <= '0;
            end
            OP_RANGE: begin
                r_rem <= n_hi[15:0];
                r_cnt <= CNT_W'(IDX_W - 1);
            end
            OP_DIV: begin
                r_rem <= trial_ge ? 16'(trial - {1'b0, tau_eff}) : trial[15:0];
                r_quo <= {r_quo[IDX_W-2:0], trial_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            OP_MUL_GA: begin
                r_dv <= $signed({r_vm[15], r_vm}) - $signed({i_cfg.rev[15], i_cfg.rev});
            end
            OP_SAT: begin
                r_cur <= sat_cur;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_cur <= r_cur;
            r_out_on  <= r_onset_valid;
        end
    end

    // flags for the sequencer
    assign o_status.fill_more = (r_k != IDX_W'(ALPHA_TABLE_DEPTH - 1));
    assign o_status.out_busy  = !out_free;
    assign o_status.no_query  = (r_kind != K_QUERY) || !r_onset_valid
                                || (r_time < r_onset_time);
    assign o_status.out_range = n_full >= r_prod[39:0];
    assign o_status.cnt_nz    = (r_cnt != '0);

    assign o_valid       = r_out_valid;
    assign o_syn_current = r_out_cur;
    assign o_is_on       = r_out_on;

endmodule

### rtl/core/asc_chk.sv
// asc_chk: port-level assertions for the alpha synapse current unit, bound to the top level.
// Depends on alpha_synapse_current_unit port names only.
module asc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_syn_current,
    input logic        o_is_on
);

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_syn_current) && $stable(o_is_on))
        else $error("stalled result changed");

    // reset drops the output and starts the fill pass with input stalled
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("reset did not stall input or clear output");

    // one request at a time: the step after a take is busy
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken on consecutive cycles");

    // nonzero current only comes from an active synapse
    a_cur_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_syn_current != 32'd0) |-> o_is_on)
        else $error("current without active onset");

endmodule

bind alpha_synapse_current_unit asc_chk u_asc_chk (.*);
